[hw/rtl/sgdm_pkg.sv]
// Shared types, widths, register indexes and helpers for the SGD momentum update.
package sgdm_pkg;

   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;
   localparam int LR_W   = 17;
   localparam int BS_W   = 16;
   localparam int MOM_W  = 17;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 17;
   localparam int REQ_DW = 80;   // 74 payload bits padded to whole bytes
   localparam int RSP_DW = 64;
   localparam int MAG_W  = 33;   // magnitude of a Q16.16 product after the shift
   localparam int STP_W  = 35;   // signed product
   localparam int SUM_W  = 37;   // widest sum before saturation

   localparam logic [CSR_AW-1:0] REG_LEARN_RATE  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_BATCH_SIZE  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_MOMENTUM    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_NESTEROV_ON = 3'd3;
   localparam logic [CSR_AW-1:0] REG_ASCEND      = 3'd4;
   localparam logic [CSR_AW-1:0] REG_ACCUMULATE  = 3'd5;

   // Side data that rides along the divider stages.
   typedef struct packed {
      logic [IDX_W-1:0]         param_index;
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] grad;
      logic                     frozen;
      logic                     grad_neg;
   } div_pay_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'(33'sh0_7FFF_FFFF));
      lo = -SUM_W'(signed'(33'sh0_8000_0000));
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

   // Signed value from a magnitude and a sign.
   function automatic logic signed [STP_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                          input logic neg);
      logic signed [STP_W-1:0] m;
      m = signed'({2'b00, mag});
      apply_sign = neg ? -m : m;
   endfunction

endpackage

[hw/rtl/sgd_momentum_weight_update.sv]
// SGD weight update with batch division, classic or Nesterov momentum, Q16.16.
// Pipeline: an accepted req beat passes the entry register, 32 divider stages
// and six arithmetic stages ending in the output register on its way to rsp.
// Throughput: one beat per cycle unless rsp_tready stalls the output; an item
// waits while one of the two items ahead still has to write the same velocity entry.
// Reset: synchronous; registers go to their reset values, then a clearing pass
// zeroes every velocity memory entry with req_tready held low.
module sgd_momentum_weight_update #(
   parameter int NUM_PARAMS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: param_index[9:0], weight_in[41:10], grad_in[73:42], zero pad
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sgdm_pkg::REQ_DW-1:0]   req_tdata,
   // req_tuser: is_recurrent[0]
   input  logic                          req_tuser,
   // rsp_tdata: weight_out[31:0], grad_out[63:32]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sgdm_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                          csr_we,
   input  logic [sgdm_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [sgdm_pkg::CSR_DW-1:0]   csr_wdata
);
   import sgdm_pkg::*;

   localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int CW = $clog2(NUM_PARAMS + 1);
   localparam logic [CW-1:0] CLR_END = CW'(NUM_PARAMS);

   // ---------------------------------------------------------------- config
   logic [LR_W-1:0]  learn_rate_ff;
   logic [BS_W-1:0]  batch_size_ff;
   logic [MOM_W-1:0] momentum_ff;
   logic             nesterov_ff;
   logic             ascend_ff;
   logic             accumulate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= LR_W'(655);
         batch_size_ff <= BS_W'(1);
         momentum_ff   <= '0;
         nesterov_ff   <= 1'b0;
         ascend_ff     <= 1'b0;
         accumulate_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_LEARN_RATE:  learn_rate_ff <= csr_wdata[LR_W-1:0];
            REG_BATCH_SIZE:  batch_size_ff <= csr_wdata[BS_W-1:0];
            REG_MOMENTUM:    momentum_ff   <= csr_wdata[MOM_W-1:0];
            REG_NESTEROV_ON: nesterov_ff   <= csr_wdata[0];
            REG_ASCEND:      ascend_ff     <= csr_wdata[0];
            REG_ACCUMULATE:  accumulate_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic mom_on;
   logic no_div;
   assign mom_on = (momentum_ff != '0);
   // A zero batch size acts as one: pass the gradient undivided.
   assign no_div = accumulate_ff || (batch_size_ff == '0);

   // ---------------------------------------------------------- clear pass
   logic [CW-1:0] clr_cnt_ff;
   logic          clearing;
   assign clearing = (clr_cnt_ff != CLR_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_ff + CW'(1);
      end
   end

   // ------------------------------------------------------- flow control
   logic out_vld_ff;
   logic adv;       // everything downstream of the velocity read moves
   logic adv_up;    // entry, divider and quotient stages move
   logic hazard;

   assign adv        = !out_vld_ff || rsp_tready;
   assign adv_up     = adv && !hazard;
   assign req_tready = adv_up && !clearing;

   // Map a parameter index onto a memory address.
   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [AW+IDX_W-1:0] wide;
      wide = {{AW{1'b0}}, idx};
      to_addr = wide[AW-1:0];
   endfunction

   // -------------------------------------------------------- entry stage
   logic                     s0_vld_ff;
   logic [IDX_W-1:0]         s0_idx_ff;
   logic signed [DATA_W-1:0] s0_w_ff;
   logic signed [DATA_W-1:0] s0_g_ff;
   logic                     s0_frz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv_up) begin
         s0_vld_ff <= req_tvalid && !clearing;
      end
      if (adv_up) begin
         s0_idx_ff <= req_tdata[9:0];
         s0_w_ff   <= req_tdata[41:10];
         s0_g_ff   <= req_tdata[73:42];
         s0_frz_ff <= req_tuser;
      end
   end

   // ------------------------------------------------------------ divider
   div_pay_type div_in_pay;
   div_pay_type div_out_pay;
   logic        div_out_vld;
   logic [31:0] div_quo;
   logic [31:0] g_abs0;
   logic [15:0] den;

   assign g_abs0 = s0_g_ff[DATA_W-1] ? 32'(-s0_g_ff) : 32'(s0_g_ff);
   assign den    = (batch_size_ff == '0) ? 16'd1 : batch_size_ff;

   always_comb begin
      div_in_pay.param_index = s0_idx_ff;
      div_in_pay.weight      = s0_w_ff;
      div_in_pay.grad        = s0_g_ff;
      div_in_pay.frozen      = s0_frz_ff;
      div_in_pay.grad_neg    = s0_g_ff[DATA_W-1];
   end

   sgdm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv_up),
      .in_vld  (s0_vld_ff),
      .in_num  (g_abs0),
      .in_den  (den),
      .in_pay  (div_in_pay),
      .out_vld (div_out_vld),
      .out_quo (div_quo),
      .out_pay (div_out_pay)
   );

   // ------------------------------------------------ quotient sign stage
   logic                     q_vld_ff;
   logic [IDX_W-1:0]         q_idx_ff;
   logic signed [DATA_W-1:0] q_w_ff;
   logic signed [DATA_W-1:0] q_g_ff;
   logic                     q_frz_ff;
   logic                     q_inr_ff;
   logic signed [DATA_W-1:0] q_g_in;

   always_comb begin
      if (div_out_pay.frozen || no_div) begin
         q_g_in = div_out_pay.grad;
      end else if (div_out_pay.grad_neg) begin
         q_g_in = -signed'(div_quo);
      end else begin
         q_g_in = signed'(div_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (adv_up) begin
         q_vld_ff <= div_out_vld;
      end
      if (adv_up) begin
         q_idx_ff <= div_out_pay.param_index;
         q_w_ff   <= div_out_pay.weight;
         q_g_ff   <= q_g_in;
         q_frz_ff <= div_out_pay.frozen;
         q_inr_ff <= (32'(div_out_pay.param_index) < 32'(NUM_PARAMS));
      end
   end

   logic q_use;
   assign q_use = q_vld_ff && !q_frz_ff && q_inr_ff && mom_on;

   // ------------------------------------------------- velocity memory
   logic signed [DATA_W-1:0] vel_mem [0:NUM_PARAMS-1];
   logic signed [DATA_W-1:0] rd_ff;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vel_mem[wr_addr] <= wr_data;
      end
      if (adv_up) begin
         rd_ff <= vel_mem[to_addr(q_idx_ff)];
      end
   end

   // ---------------------------------------------- M1: learning-rate step
   logic                     m1_vld_ff;
   logic [IDX_W-1:0]         m1_idx_ff;
   logic signed [DATA_W-1:0] m1_w_ff;
   logic signed [DATA_W-1:0] m1_g_ff;
   logic                     m1_frz_ff;
   logic                     m1_use_ff;
   logic [MAG_W-1:0]         m1_smag_ff;
   logic                     m1_sneg_ff;
   logic [31:0]              q_g_abs;
   logic [LR_W+31:0]         lr_prod;

   assign q_g_abs = q_g_ff[DATA_W-1] ? 32'(-q_g_ff) : 32'(q_g_ff);
   assign lr_prod = learn_rate_ff * q_g_abs;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         // Hold the quotient stage and drop a bubble in on a velocity hazard.
         m1_vld_ff <= q_vld_ff && !hazard;
      end
      if (adv) begin
         m1_idx_ff  <= q_idx_ff;
         m1_w_ff    <= q_w_ff;
         m1_g_ff    <= q_g_ff;
         m1_frz_ff  <= q_frz_ff;
         m1_use_ff  <= q_use;
         m1_smag_ff <= lr_prod[LR_W+31:16];
         m1_sneg_ff <= q_g_ff[DATA_W-1] ^ !ascend_ff;
      end
   end

   // ------------------------------------------- M2: momentum times velocity
   logic                     m2_vld_ff;
   logic [IDX_W-1:0]         m2_idx_ff;
   logic signed [DATA_W-1:0] m2_w_ff;
   logic signed [DATA_W-1:0] m2_g_ff;
   logic                     m2_frz_ff;
   logic                     m2_use_ff;
   logic signed [STP_W-1:0]  m2_step_ff;
   logic signed [STP_W-1:0]  m2_mv_ff;
   logic signed [DATA_W-1:0] v_old;
   logic [31:0]              v_abs;
   logic [MOM_W+31:0]        mv_prod;

   // Out-of-range entries read as zero.
   assign v_old   = m1_use_ff ? rd_ff : '0;
   assign v_abs   = v_old[DATA_W-1] ? 32'(-v_old) : 32'(v_old);
   assign mv_prod = momentum_ff * v_abs;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= m1_vld_ff;
      end
      if (adv) begin
         m2_idx_ff  <= m1_idx_ff;
         m2_w_ff    <= m1_w_ff;
         m2_g_ff    <= m1_g_ff;
         m2_frz_ff  <= m1_frz_ff;
         m2_use_ff  <= m1_use_ff;
         m2_step_ff <= apply_sign(m1_smag_ff, m1_sneg_ff);
         m2_mv_ff   <= apply_sign(mv_prod[MOM_W+31:16], v_old[DATA_W-1]);
      end
   end

   // ---------------------------------------------- M3: new velocity, write
   logic                     m3_vld_ff;
   logic signed [DATA_W-1:0] m3_w_ff;
   logic signed [DATA_W-1:0] m3_g_ff;
   logic                     m3_frz_ff;
   logic signed [STP_W-1:0]  m3_step_ff;
   logic signed [DATA_W-1:0] m3_vnew_ff;
   logic signed [DATA_W-1:0] vnew_in;

   assign vnew_in = sat32(SUM_W'(m2_mv_ff) + SUM_W'(m2_step_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = to_addr(m2_idx_ff);
      wr_data = vnew_in;
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff[AW-1:0];
         wr_data = '0;
      end else if (adv && m2_vld_ff && m2_use_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else if (adv) begin
         m3_vld_ff <= m2_vld_ff;
      end
      if (adv) begin
         m3_w_ff    <= m2_w_ff;
         m3_g_ff    <= m2_g_ff;
         m3_frz_ff  <= m2_frz_ff;
         m3_step_ff <= m2_step_ff;
         m3_vnew_ff <= vnew_in;
      end
   end

   // An item about to read its velocity must not pass one of the same entry
   // that has read but not yet written.
   assign hazard = q_use &&
      ((m1_vld_ff && m1_use_ff && (m1_idx_ff == q_idx_ff)) ||
       (m2_vld_ff && m2_use_ff && (m2_idx_ff == q_idx_ff)));

   // -------------------------------------- M4: momentum times new velocity
   logic                     m4_vld_ff;
   logic signed [DATA_W-1:0] m4_w_ff;
   logic signed [DATA_W-1:0] m4_g_ff;
   logic                     m4_frz_ff;
   logic signed [STP_W-1:0]  m4_step_ff;
   logic signed [DATA_W-1:0] m4_vnew_ff;
   logic signed [STP_W-1:0]  m4_mvn_ff;
   logic [31:0]              vn_abs;
   logic [MOM_W+31:0]        mvn_prod;

   assign vn_abs   = m3_vnew_ff[DATA_W-1] ? 32'(-m3_vnew_ff) : 32'(m3_vnew_ff);
   assign mvn_prod = momentum_ff * vn_abs;

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_vld_ff <= 1'b0;
      end else if (adv) begin
         m4_vld_ff <= m3_vld_ff;
      end
      if (adv) begin
         m4_w_ff    <= m3_w_ff;
         m4_g_ff    <= m3_g_ff;
         m4_frz_ff  <= m3_frz_ff;
         m4_step_ff <= m3_step_ff;
         m4_vnew_ff <= m3_vnew_ff;
         m4_mvn_ff  <= apply_sign(mvn_prod[MOM_W+31:16], m3_vnew_ff[DATA_W-1]);
      end
   end

   // ------------------------------------------ output register: new weight
   logic signed [DATA_W-1:0] wout_ff;
   logic signed [DATA_W-1:0] gout_ff;
   logic signed [SUM_W-1:0]  wsum;
   logic signed [DATA_W-1:0] wout_in;

   always_comb begin
      if (!mom_on) begin
         wsum = SUM_W'(m4_w_ff) + SUM_W'(m4_step_ff);
      end else if (nesterov_ff) begin
         wsum = SUM_W'(m4_w_ff) + SUM_W'(m4_mvn_ff) + SUM_W'(m4_step_ff);
      end else begin
         wsum = SUM_W'(m4_w_ff) + SUM_W'(m4_vnew_ff);
      end
      // Frozen parameters pass through untouched.
      wout_in = m4_frz_ff ? m4_w_ff : sat32(wsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= m4_vld_ff;
      end
      if (adv) begin
         wout_ff <= wout_in;
         gout_ff <= m4_g_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {gout_ff, wout_ff};

endmodule

[hw/rtl/sgdm_div.sv]
// Pipelined restoring divider: 32-bit magnitude by 16-bit divisor, one quotient bit a stage.
module sgdm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic [31:0]                in_num,
   input  logic [15:0]                in_den,
   input  sgdm_pkg::div_pay_type      in_pay,
   output logic                       out_vld,
   output logic [31:0]                out_quo,
   output sgdm_pkg::div_pay_type      out_pay
);
   import sgdm_pkg::*;

   localparam int STAGES = 32;

   logic          vld_ff [1:STAGES];
   logic [15:0]   rem_ff [1:STAGES];
   logic [31:0]   nq_ff  [1:STAGES];
   div_pay_type   pay_ff [1:STAGES];

   logic          src_vld [0:STAGES-1];
   logic [15:0]   src_rem [0:STAGES-1];
   logic [31:0]   src_nq  [0:STAGES-1];
   div_pay_type   src_pay [0:STAGES-1];
   logic [15:0]   rem_in  [0:STAGES-1];
   logic [31:0]   nq_in   [0:STAGES-1];

   always_comb begin
      src_vld[0] = in_vld;
      src_rem[0] = '0;
      src_nq[0]  = in_num;
      src_pay[0] = in_pay;
      for (int k = 1; k < STAGES; k++) begin
         src_vld[k] = vld_ff[k];
         src_rem[k] = rem_ff[k];
         src_nq[k]  = nq_ff[k];
         src_pay[k] = pay_ff[k];
      end
   end

   // One trial subtraction per stage; remainder stays below the divisor.
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         logic [16:0] trial;
         trial = {src_rem[k], src_nq[k][31]};
         if (trial >= {1'b0, in_den}) begin
            rem_in[k] = 16'(trial - {1'b0, in_den});
            nq_in[k]  = {src_nq[k][30:0], 1'b1};
         end else begin
            rem_in[k] = trial[15:0];
            nq_in[k]  = {src_nq[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= src_vld[k];
         end
         if (en) begin
            rem_ff[k+1] <= rem_in[k];
            nq_ff[k+1]  <= nq_in[k];
            pay_ff[k+1] <= src_pay[k];
         end
      end
   end

   assign out_vld = vld_ff[STAGES];
   assign out_quo = nq_ff[STAGES];
   assign out_pay = pay_ff[STAGES];

endmodule

[tb/tb_sgd_momentum_weight_update.sv]
// Self-checking testbench for the SGD momentum weight update block.
module tb_sgd_momentum_weight_update;
   import sgdm_pkg::*;

   localparam int NPAR = 1024;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_DW-1:0]    req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DW-1:0]    rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_AW-1:0]    csr_addr = '0;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   sgd_momentum_weight_update #(.NUM_PARAMS(NPAR)) DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] g;
      logic                     rec;
   } upd_req_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] g;
   } upd_rsp_t;

   // Shadow registers and velocity copy
   logic [LR_W-1:0]  lr_q;
   logic [BS_W-1:0]  bs_q;
   logic [MOM_W-1:0] mom_q;
   logic             nest_q, asc_q, acc_q;
   logic signed [DATA_W-1:0] vel_shadow [NPAR];

   upd_rsp_t expected_q[$];
   int       err_cnt = 0;
   bit       hold_off = 1'b0;
   bit       calm = 1'b0;   // no idling on either side

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      err_cnt++;
   endtask

   function automatic longint sat_q(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Unsigned Q16.16 factor times signed value, truncated toward zero
   function automatic longint q_scale(input longint f, input longint x);
      longint mag;
      mag = (x < 0) ? -x : x;
      mag = (f * mag) >>> 16;
      return (x < 0) ? -mag : mag;
   endfunction

   function automatic upd_rsp_t compute_update(input upd_req_t r);
      upd_rsp_t o;
      longint w, g, step, v, wn;
      w = r.w;
      g = r.g;
      if (r.rec) begin
         o.w = r.w;
         o.g = r.g;
         return o;
      end
      if (!acc_q && bs_q != 0) g = g / longint'(bs_q);
      step = q_scale(lr_q, g);
      if (!asc_q) step = -step;
      if (mom_q == 0) begin
         wn = sat_q(w + step);
      end else begin
         v = vel_shadow[r.idx];
         v = sat_q(q_scale(mom_q, v) + step);
         vel_shadow[r.idx] = v[31:0];
         if (nest_q) wn = sat_q(w + q_scale(mom_q, v) + step);
         else wn = sat_q(w + v);
      end
      o.w = wn[31:0];
      o.g = g[31:0];
      return o;
   endfunction

   task automatic write_csr(input logic [CSR_AW-1:0] a, input logic [CSR_DW-1:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (a)
         REG_LEARN_RATE:  lr_q   = d[LR_W-1:0];
         REG_BATCH_SIZE:  bs_q   = d[BS_W-1:0];
         REG_MOMENTUM:    mom_q  = d[MOM_W-1:0];
         REG_NESTEROV_ON: nest_q = d[0];
         REG_ASCEND:      asc_q  = d[0];
         REG_ACCUMULATE:  acc_q  = d[0];
         default: ;
      endcase
   endtask

   // Offer one beat, wait until accepted, record the prediction at acceptance
   task automatic send_update(input upd_req_t r);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.g, r.w, r.idx};
      req_tuser  <= r.rec;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(compute_update(r));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   function automatic upd_req_t rand_update(input int mode);
      upd_req_t r;
      r.idx = (mode == 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom);
      case ($urandom_range(3))
         0: r.w = $urandom;
         1: r.w = $signed($urandom_range(65536 * 8)) - 32'sd262144;
         2: r.w = ($urandom_range(1)) ? 32'sh7FFF_F000 : 32'sh8000_1000;
         default: r.w = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
      r.g   = ($urandom_range(2) == 0) ? $urandom
              : $signed($urandom_range(65536 * 64)) - 32'sd2097152;
      r.rec = ($urandom_range(9) == 0);
      return r;
   endfunction

   // Response side: random stalls, one long hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_off && (calm || $urandom_range(99) >= 18);
      end
   end

   // Compare each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      upd_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.w = rsp_tdata[31:0];
         got.g = rsp_tdata[63:32];
         if (expected_q.size() == 0) begin
            $display("unexpected result beat at %0t", $time);
            err_cnt++;
         end else begin
            want = expected_q.pop_front();
            if (got.w !== want.w) report("weight_out", got.w, want.w);
            if (got.g !== want.g) report("grad_out", got.g, want.g);
         end
      end
   end

   // Directed rows: stimulus plus a typed-in answer where obvious
   typedef struct {
      upd_req_t r;
      bit       known;
      upd_rsp_t ans;
   } row_t;

   initial begin
      row_t rows[$];
      row_t rw;
      upd_rsp_t p;
      int cfg;
      for (int i = 0; i < NPAR; i++) vel_shadow[i] = '0;
      lr_q = 17'd655; bs_q = 16'd1; mom_q = '0;
      nest_q = 1'b0; asc_q = 1'b0; acc_q = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset: plain SGD, lr 655, batch 1
      rw.known = 1; rw.r = '{10'd0, 32'sd0, 32'sd0, 1'b0}; rw.ans = '{32'sd0, 32'sd0};
      rows.push_back(rw);
      rw.r = '{10'd1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1};
      rw.ans = '{32'sh7FFF_FFFF, 32'sh8000_0000}; rows.push_back(rw);
      rw.r = '{10'd5, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1};
      rw.ans = '{32'sh8000_0000, 32'sh7FFF_FFFF}; rows.push_back(rw);
      rw.known = 0;
      rw.r = '{10'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0}; rows.push_back(rw);
      rw.r = '{10'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0}; rows.push_back(rw);
      rw.r = '{10'd4, 32'sh0001_0000, 32'sh0001_0000, 1'b0}; rows.push_back(rw);
      rw.r = '{10'd1023, 32'shFFFF_FFFF, 32'sh0000_0001, 1'b0}; rows.push_back(rw);
      foreach (rows[i]) begin
         send_update(rows[i].r);
         if (rows[i].known) begin
            p = expected_q[$];
            if (p !== rows[i].ans) begin
               $display("directed row %0d predicts %h, table says %h", i, p, rows[i].ans);
               err_cnt++;
            end
         end
      end
      drain();

      // Classic momentum, learning rate and momentum at 1.0, zero batch size
      write_csr(REG_LEARN_RATE, 17'd65536);
      write_csr(REG_MOMENTUM, 17'd65536);
      write_csr(REG_BATCH_SIZE, 17'd0);
      write_csr(REG_ASCEND, 17'd1);
      write_csr(REG_NESTEROV_ON, 17'd0);
      write_csr(REG_ACCUMULATE, 17'd0);
      for (int i = 0; i < 6; i++)
         send_update('{10'd7, 32'sh4000_0000, 32'sh4000_0000, 1'b0});
      send_update('{10'd7, 32'sh0, 32'sh8000_0000, 1'b1});
      drain();
      write_csr(REG_NESTEROV_ON, 17'd1);
      write_csr(REG_ASCEND, 17'd0);
      write_csr(REG_BATCH_SIZE, 17'd65535);
      for (int i = 0; i < 6; i++)
         send_update('{10'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0});
      send_update('{10'd8, 32'sh1234_5678, 32'shFFFF_0000, 1'b0});
      drain();

      // Random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_LEARN_RATE, (ph % 3 == 0) ? 17'd65536 : LR_W'($urandom_range(65536)));
         write_csr(REG_BATCH_SIZE,
                   CSR_DW'((ph == 2) ? 16'd65535 : BS_W'($urandom_range(1, 8))));
         cfg = $urandom_range(3);
         write_csr(REG_MOMENTUM, (ph == 1) ? 17'd0 : (ph == 5) ? 17'd65536
                   : MOM_W'($urandom_range(65536)));
         write_csr(REG_NESTEROV_ON, CSR_DW'(ph[0]));
         write_csr(REG_ASCEND, CSR_DW'(ph[1]));
         write_csr(REG_ACCUMULATE, CSR_DW'(cfg == 0));
         calm = (ph == 3);
         if (ph == 4) begin
            // Long receiver hold-off while the sender keeps offering beats
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
               for (int i = 0; i < 150; i++) send_update(rand_update(0));
            join
         end else begin
            for (int i = 0; i < 150; i++) send_update(rand_update(ph % 2));
         end
         drain();
      end
      calm = 1'b0;

      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run limit: clearing pass plus ~1300 beats under stalls, many times over
   initial begin
      #(8 * 400000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/sgdm_pkg.sv
hw/rtl/sgdm_div.sv
hw/rtl/sgd_momentum_weight_update.sv
tb/tb_sgd_momentum_weight_update.sv
